// ----- hw/rtl/sstok_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sstok_pkg
// Shared types, character codes and token kinds of the source tokenizer.
// ----------------------------------------------------------------------------
package sstok_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // Result queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UPPER_LO   = 8'h41;
    localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_LO   = 8'h61;
    localparam logic [7:0] CH_LOWER_HI   = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [4:0] {
        KIND_ILLEGAL = 5'd0,
        KIND_EOF     = 5'd1,
        KIND_IDENT   = 5'd2,
        KIND_INT     = 5'd3,
        KIND_STRING  = 5'd4,
        KIND_ASSIGN  = 5'd5,
        KIND_PLUS    = 5'd6,
        KIND_MINUS   = 5'd7,
        KIND_BANG    = 5'd8,
        KIND_STAR    = 5'd9,
        KIND_SLASH   = 5'd10,
        KIND_LT      = 5'd11,
        KIND_GT      = 5'd12,
        KIND_EQ      = 5'd13,
        KIND_NOTEQ   = 5'd14,
        KIND_COMMA   = 5'd15,
        KIND_SEMI    = 5'd16,
        KIND_LPAREN  = 5'd17,
        KIND_RPAREN  = 5'd18,
        KIND_LBRACE  = 5'd19,
        KIND_RBRACE  = 5'd20
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_IDENT     = 3'd1,
        MODE_INT       = 3'd2,
        MODE_STRING    = 3'd3,
        MODE_PEND_EQ   = 3'd4,
        MODE_PEND_BANG = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        t_kind       token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_token;

    // Map a one-byte operator or punctuation mark to its kind; anything
    // else is illegal.
    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LT:     k = KIND_LT;
            CH_GT:     k = KIND_GT;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/script_source_tokenizer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// script_source_tokenizer_unit
// Streaming lexer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one source
//   byte per transfer, or an end marker (is_end set, or a zero byte).
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//   token per transfer: kind, start offset, length and a flag marking the
//   last token caused by a given byte. A byte yields zero, one or two
//   tokens; the end marker always yields EOF and then restarts at offset 0.
//   A byte taken is held in the input register and lexed from there into
//   the token queue; its first token is offered on the output from the queue.
//   Throughput: one byte per cycle. The lexer stage has one input register
//   and writes into a four-entry token queue; it advances while at least
//   two queue slots are free, so the output port's one token per cycle is
//   the bound when bytes yield two tokens.
//   Reset: scan mode goes idle, offsets and run length clear, queue empties.
//   Output stall: tokens hold in the queue; once fewer than two slots are
//   free the held byte waits and o_in_stall rises.
// ----------------------------------------------------------------------------
module script_source_tokenizer_unit #(
    parameter int OFFSET_BITS = sstok_pkg::OFFSET_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire sstok_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output sstok_pkg::t_token     o_out_data
);

    localparam int OB = OFFSET_BITS;

    function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
        return (&v) ? v : v + OB'(1);
    endfunction

    // Clip a counter to the 16-bit output fields.
    function automatic logic [15:0] clip16(input logic [OB-1:0] v);
        logic [OB+15:0] w;
        w = {16'd0, v};
        return (|w[OB+15:16]) ? 16'hFFFF : w[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                r_in_vld;
    sstok_pkg::t_in_item r_in;
    logic                room;
    logic                proc;
    logic                load;

    assign proc       = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign load       = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    sstok_pkg::t_mode r_mode, n_mode;
    logic [OB-1:0]    r_offset, n_offset;
    logic [OB-1:0]    r_start, n_start;
    logic [OB-1:0]    r_len, n_len;

    // Character classes of the held byte
    logic [7:0] c;
    logic       end_c;
    logic       c_letter, c_digit, c_space, c_eq, c_bang, c_quote;

    assign c        = r_in.text_byte;
    assign end_c    = r_in.is_end || (c == sstok_pkg::CH_NUL);
    assign c_letter = (c >= sstok_pkg::CH_LOWER_LO && c <= sstok_pkg::CH_LOWER_HI)
                   || (c >= sstok_pkg::CH_UPPER_LO && c <= sstok_pkg::CH_UPPER_HI)
                   || (c == sstok_pkg::CH_UNDERSCORE);
    assign c_digit  = c >= sstok_pkg::CH_DIGIT_LO && c <= sstok_pkg::CH_DIGIT_HI;
    assign c_space  = c == sstok_pkg::CH_SPACE || c == sstok_pkg::CH_TAB
                   || c == sstok_pkg::CH_LF || c == sstok_pkg::CH_CR;
    assign c_eq     = c == sstok_pkg::CH_EQUAL;
    assign c_bang   = c == sstok_pkg::CH_BANG;
    assign c_quote  = c == sstok_pkg::CH_QUOTE;

    // Mode decode: does the byte extend the open run, close it, and what
    // token does the open run flush as.
    logic             m_cont, m_close, m_open, restart;
    sstok_pkg::t_kind f_kind, cl_kind;
    logic [OB-1:0]    f_len, cl_len;

    always_comb begin
        m_cont  = 1'b0;
        m_close = 1'b0;
        m_open  = 1'b0;
        f_kind  = sstok_pkg::KIND_ILLEGAL;
        f_len   = r_len;
        cl_kind = sstok_pkg::KIND_ILLEGAL;
        cl_len  = r_len;
        unique case (r_mode)
            sstok_pkg::MODE_IDENT: begin
                m_cont = c_letter;
                m_open = 1'b1;
                f_kind = sstok_pkg::KIND_IDENT;
            end
            sstok_pkg::MODE_INT: begin
                m_cont = c_digit;
                m_open = 1'b1;
                f_kind = sstok_pkg::KIND_INT;
            end
            sstok_pkg::MODE_STRING: begin
                // An open string at end of text flushes as illegal
                m_cont  = !c_quote;
                m_close = c_quote;
                m_open  = 1'b1;
                cl_kind = sstok_pkg::KIND_STRING;
            end
            sstok_pkg::MODE_PEND_EQ: begin
                m_close = c_eq;
                m_open  = 1'b1;
                f_kind  = sstok_pkg::KIND_ASSIGN;
                f_len   = OB'(1);
                cl_kind = sstok_pkg::KIND_EQ;
                cl_len  = OB'(2);
            end
            sstok_pkg::MODE_PEND_BANG: begin
                m_close = c_eq;
                m_open  = 1'b1;
                f_kind  = sstok_pkg::KIND_BANG;
                f_len   = OB'(1);
                cl_kind = sstok_pkg::KIND_NOTEQ;
                cl_len  = OB'(2);
            end
            default: begin
            end
        endcase
    end

    assign restart = !m_cont && !m_close;

    // Next state
    always_comb begin
        n_mode   = r_mode;
        n_offset = r_offset;
        n_start  = r_start;
        n_len    = r_len;
        if (proc) begin
            if (end_c) begin
                n_mode   = sstok_pkg::MODE_IDLE;
                n_offset = '0;
                n_start  = '0;
                n_len    = '0;
            end else begin
                n_offset = sat_inc(r_offset);
                if (m_cont) begin
                    n_len = sat_inc(r_len);
                end else if (m_close) begin
                    n_mode = sstok_pkg::MODE_IDLE;
                end else begin
                    // Start the next token at this byte
                    n_mode = sstok_pkg::MODE_IDLE;
                    if (!c_space) begin
                        n_start = r_offset;
                        n_len   = OB'(1);
                        if (c_eq) begin
                            n_mode = sstok_pkg::MODE_PEND_EQ;
                        end else if (c_bang) begin
                            n_mode = sstok_pkg::MODE_PEND_BANG;
                        end else if (c_quote) begin
                            n_mode  = sstok_pkg::MODE_STRING;
                            n_start = sat_inc(r_offset);
                            n_len   = '0;
                        end else if (c_letter) begin
                            n_mode = sstok_pkg::MODE_IDENT;
                        end else if (c_digit) begin
                            n_mode = sstok_pkg::MODE_INT;
                        end
                    end
                end
            end
        end
    end

    // Tokens: slot A flushes or closes the open run, slot B is the token
    // begun by this byte (single-byte or illegal) or EOF.
    logic              a_v, b_v;
    sstok_pkg::t_token tok_a, tok_b;

    always_comb begin
        a_v = proc && (end_c ? m_open : (m_close || (restart && m_open)));
        b_v = proc && (end_c || (restart && !c_space && !c_eq && !c_bang
                                 && !c_quote && !c_letter && !c_digit));

        tok_a.token_start  = clip16(r_start);
        tok_a.last_of_run  = !b_v;
        if (m_close && !end_c) begin
            tok_a.token_kind   = cl_kind;
            tok_a.token_length = clip16(cl_len);
        end else begin
            tok_a.token_kind   = f_kind;
            tok_a.token_length = clip16(f_len);
        end

        tok_b.token_kind   = end_c ? sstok_pkg::KIND_EOF : sstok_pkg::single_kind(c);
        tok_b.token_start  = clip16(r_offset);
        tok_b.token_length = 16'd1;
        tok_b.last_of_run  = 1'b1;
    end

    // ------------------------------------------------------------------
    // Token queue
    // ------------------------------------------------------------------
    sstok_pkg::t_token                r_q [sstok_pkg::OQ_DEPTH];
    logic [sstok_pkg::OQ_PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [sstok_pkg::OQ_CNT_W-1:0]   r_count, n_count;
    logic [1:0]                       push_n;
    logic                             pop;
    sstok_pkg::t_token                slot0;

    // Advance the held byte only while two slots are free
    assign room        = r_count <= sstok_pkg::OQ_CNT_W'(sstok_pkg::OQ_DEPTH - 2);

    assign push_n      = {1'b0, a_v} + {1'b0, b_v};
    assign slot0       = a_v ? tok_a : tok_b;
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_q[r_rd];
    assign pop         = o_out_valid && !i_out_stall;

    assign n_wr    = r_wr + sstok_pkg::OQ_PTR_W'(push_n);
    assign n_rd    = r_rd + sstok_pkg::OQ_PTR_W'(pop);
    assign n_count = r_count + sstok_pkg::OQ_CNT_W'(push_n)
                   - sstok_pkg::OQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= sstok_pkg::MODE_IDLE;
            r_offset <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
        end else begin
            if (load) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_len    <= n_len;
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_count  <= n_count;
        end
    end

    // Payload: held byte and queued tokens
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_data;
        end
        if (push_n != 2'd0) begin
            r_q[r_wr] <= slot0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr + sstok_pkg::OQ_PTR_W'(1)] <= tok_b;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sstok_pkg::OQ_CNT_W'(sstok_pkg::OQ_DEPTH))
        else $error("token queue overfilled");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && end_c) |=> (r_offset == '0 && r_mode == sstok_pkg::MODE_IDLE))
        else $error("end of text did not restart the scanner");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_kind == sstok_pkg::KIND_EOF)
            |-> o_out_data.last_of_run)
        else $error("EOF token not marked last");

    a_offset_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(proc && end_c) |=> (r_offset >= $past(r_offset)))
        else $error("byte offset moved backward without end of text");
`endif

endmodule
`default_nettype wire

// ----- tb/script_source_tokenizer_unit_checker.sv -----
// ----------------------------------------------------------------------------
// script_source_tokenizer_unit_checker
// Watches both channels, lexes each accepted byte and checks every token.
// ----------------------------------------------------------------------------
module script_source_tokenizer_unit_checker #(
    parameter int OFFSET_BITS = sstok_pkg::OFFSET_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  sstok_pkg::t_in_item i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  sstok_pkg::t_token   i_out_data,
    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_tokens_checked
);
    import sstok_pkg::*;

    localparam int MAX_REPORTS = 30;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // Lexer state as the block should hold it
    t_mode                  scan_mode = MODE_IDLE;
    logic [OFFSET_BITS-1:0] byte_pos  = '0;
    logic [OFFSET_BITS-1:0] tok_start = '0;
    logic [OFFSET_BITS-1:0] tok_len   = '0;

    t_token predicted_tokens[$];
    int     fail_total = 0;
    int     checked_total = 0;

    assign o_fail_count     = fail_total;
    assign o_tokens_checked = checked_total;

    function automatic logic [OFFSET_BITS-1:0] bump(input logic [OFFSET_BITS-1:0] v);
        return (v == OFFSET_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clip16(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
               (c >= CH_UPPER_LO && c <= CH_UPPER_HI) || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        case (c)
            CH_PLUS:   return KIND_PLUS;
            CH_MINUS:  return KIND_MINUS;
            CH_STAR:   return KIND_STAR;
            CH_SLASH:  return KIND_SLASH;
            CH_LT:     return KIND_LT;
            CH_GT:     return KIND_GT;
            CH_COMMA:  return KIND_COMMA;
            CH_SEMI:   return KIND_SEMI;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            default:   return KIND_ILLEGAL;
        endcase
    endfunction

    function automatic t_token make_token(input t_kind k,
                                          input logic [OFFSET_BITS-1:0] s,
                                          input logic [OFFSET_BITS-1:0] l);
        t_token t;
        t.token_kind   = k;
        t.token_start  = clip16(s);
        t.token_length = clip16(l);
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Token left open by the current mode when something ends it early
    function automatic t_token open_token();
        case (scan_mode)
            MODE_IDENT:     return make_token(KIND_IDENT, tok_start, tok_len);
            MODE_INT:       return make_token(KIND_INT, tok_start, tok_len);
            MODE_STRING:    return make_token(KIND_ILLEGAL, tok_start, tok_len);
            MODE_PEND_EQ:   return make_token(KIND_ASSIGN, tok_start, OFFSET_BITS'(1));
            default:        return make_token(KIND_BANG, tok_start, OFFSET_BITS'(1));
        endcase
    endfunction

    task automatic lex_byte(input t_in_item item);
        t_token     toks[2];
        int         n;
        logic [7:0] c;
        bit         restart;
        n       = 0;
        c       = item.text_byte;
        restart = 1'b0;
        if (item.is_end || c == CH_NUL) begin
            if (scan_mode != MODE_IDLE) begin
                toks[n] = open_token();
                n++;
            end
            toks[n] = make_token(KIND_EOF, byte_pos, OFFSET_BITS'(1));
            n++;
            scan_mode = MODE_IDLE;
            byte_pos  = '0;
            tok_start = '0;
            tok_len   = '0;
        end else begin
            case (scan_mode)
                MODE_IDENT: begin
                    if (is_letter(c)) tok_len = bump(tok_len);
                    else restart = 1'b1;
                end
                MODE_INT: begin
                    if (is_digit(c)) tok_len = bump(tok_len);
                    else restart = 1'b1;
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        toks[n] = make_token(KIND_STRING, tok_start, tok_len);
                        n++;
                        scan_mode = MODE_IDLE;
                    end else begin
                        tok_len = bump(tok_len);
                    end
                end
                MODE_PEND_EQ, MODE_PEND_BANG: begin
                    if (c == CH_EQUAL) begin
                        toks[n] = make_token((scan_mode == MODE_PEND_EQ) ? KIND_EQ : KIND_NOTEQ,
                                             tok_start, OFFSET_BITS'(2));
                        n++;
                        scan_mode = MODE_IDLE;
                    end else begin
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase
            if (restart) begin
                if (scan_mode != MODE_IDLE) begin
                    toks[n] = open_token();
                    n++;
                end
                scan_mode = MODE_IDLE;
                if (!is_blank(c)) begin
                    tok_start = byte_pos;
                    tok_len   = OFFSET_BITS'(1);
                    if (c == CH_EQUAL) begin
                        scan_mode = MODE_PEND_EQ;
                    end else if (c == CH_BANG) begin
                        scan_mode = MODE_PEND_BANG;
                    end else if (c == CH_QUOTE) begin
                        scan_mode = MODE_STRING;
                        tok_start = bump(byte_pos);
                        tok_len   = '0;
                    end else if (is_letter(c)) begin
                        scan_mode = MODE_IDENT;
                    end else if (is_digit(c)) begin
                        scan_mode = MODE_INT;
                    end else begin
                        toks[n] = make_token(punct_kind(c), byte_pos, OFFSET_BITS'(1));
                        n++;
                    end
                end
            end
            byte_pos = bump(byte_pos);
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) toks[i].last_of_run = 1'b1;
            predicted_tokens.push_back(toks[i]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_total < MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
        fail_total++;
    endtask

    task automatic compare_token(input t_token got);
        t_token want;
        if (predicted_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected token kind=%0d start=%0d len=%0d",
                                      got.token_kind, got.token_start, got.token_length));
        end else begin
            want = predicted_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report_mismatch($sformatf("kind got %0d want %0d",
                                          got.token_kind, want.token_kind));
            if (got.token_start !== want.token_start)
                report_mismatch($sformatf("start got %0d want %0d",
                                          got.token_start, want.token_start));
            if (got.token_length !== want.token_length)
                report_mismatch($sformatf("length got %0d want %0d",
                                          got.token_length, want.token_length));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last flag got %0b want %0b (kind %0d)",
                                          got.last_of_run, want.last_of_run,
                                          want.token_kind));
        end
        checked_total++;
    endtask

    // Outputs leave first: a token accepted at this edge never comes from a
    // byte accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_mode = MODE_IDLE;
            byte_pos  = '0;
            tok_start = '0;
            tok_len   = '0;
            predicted_tokens.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) compare_token(i_out_data);
            if (i_in_valid && !i_in_stall) lex_byte(i_in_data);
            o_pending <= predicted_tokens.size();
        end
    end

endmodule

// ----- tb/script_source_tokenizer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// script_source_tokenizer_unit_tb
// Streams directed and random source text into the tokenizer, with random
// idling on both channels and a long output hold-off; the checker beside
// the block predicts and compares every token.
// ----------------------------------------------------------------------------
module script_source_tokenizer_unit_tb;
    import sstok_pkg::*;

    localparam int RANDOM_BYTES     = 1600;
    localparam int TAIL_BYTES       = 200;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int SETTLE_CYCLES    = 20;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_in_item in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_token   out_data;

    int pending;
    int fail_count;
    int tokens_checked;

    int bytes_sent     = 0;
    int texts_sent     = 0;
    int cycle_count    = 0;
    bit gaps_on        = 1'b1;  // sender may idle between transfers
    bit calm           = 1'b0;  // final stretch: no idling on either side
    bit long_hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    script_source_tokenizer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    script_source_tokenizer_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .o_pending        (pending),
        .o_fail_count     (fail_count),
        .o_tokens_checked (tokens_checked)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d tokens still owed", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until a transfer happens. A random gap may
    // come first; valid is only lowered when a gap actually follows, so a
    // back-to-back byte never sees valid dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic end_flag);
        t_in_item item;
        item.text_byte = b;
        item.is_end    = end_flag;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (in_stall);
        bytes_sent++;
        if (end_flag || b == CH_NUL) texts_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Drop valid and wait until every predicted token has left the block
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 2))
            0:       return CH_LOWER_LO + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_LO + 8'($urandom_range(0, 25));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Anything inside quotes except the closing quote and the end byte
    function automatic logic [7:0] pick_string_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
        return c;
    endfunction

    // Bytes that belong to no token class, including the upper half
    function automatic logic [7:0] pick_illegal();
        string odd_marks;
        odd_marks = "#$%&'.:?@[]^`|~";
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(128, 255));
            2:       return odd_marks[$urandom_range(0, odd_marks.len() - 1)];
            default: return $urandom_range(0, 1) ? 8'h01 : 8'h7F;
        endcase
    endfunction

    // End a text with the end flag (byte is don't-care) or with a zero byte
    task automatic send_end_marker();
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        else send_byte(CH_NUL, 1'b0);
    endtask

    // One well-formed program fragment with random content, some noise mixed
    // in, and now and then a string left open at the end.
    task automatic send_random_text(input int max_tokens);
        string ops;
        int    n_tok;
        ops   = "+-*/<>,;(){}";
        n_tok = $urandom_range(1, max_tokens);
        for (int k = 0; k < n_tok; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 7)) send_byte(pick_letter(), 1'b0);
                end
                5, 6, 7: begin
                    repeat ($urandom_range(1, 5))
                        send_byte(CH_DIGIT_LO + 8'($urandom_range(0, 9)), 1'b0);
                end
                8, 9: begin
                    send_byte(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 6)) send_byte(pick_string_char(), 1'b0);
                    send_byte(CH_QUOTE, 1'b0);
                end
                10, 11, 12: send_byte(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
                13, 14: begin
                    send_byte(CH_EQUAL, 1'b0);
                    if ($urandom_range(0, 1)) send_byte(CH_EQUAL, 1'b0);
                end
                15, 16: begin
                    send_byte(CH_BANG, 1'b0);
                    if ($urandom_range(0, 1)) send_byte(CH_EQUAL, 1'b0);
                end
                17: repeat ($urandom_range(1, 3)) send_byte(pick_blank(), 1'b0);
                18: send_byte(pick_illegal(), 1'b0);
                default: send_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
            // Leave tokens glued together half the time
            if ($urandom_range(0, 1)) send_byte(pick_blank(), 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_byte(pick_string_char(), 1'b0);
        end
        send_end_marker();
    endtask

    // ------------------------------------------------------------------------
    // Token sink: random stall bursts, one long hold-off while the source
    // keeps offering, and no stalls at all in the calm tail.
    // ------------------------------------------------------------------------
    initial begin : token_sink
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!long_hold_done && bytes_sent >= LONG_HOLD_AT) begin
                // Fill the token queue so the block must stall its input
                out_stall      <= 1'b1;
                hold           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                hold      = $urandom_range(1, 19);
            end else begin
                out_stall <= 1'b0;
                hold      = calm ? 1 : $urandom_range(1, 24);
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every operator and punctuation mark; a pending bang flushed by an
        // end flag that carries the top byte value
        send_text("+-*/<>,;(){}!");
        send_byte(8'hFF, 1'b1);
        // Letters then digits back to back, eq, noteq, bang before a letter,
        // and a pending assign flushed by a zero byte
        send_text("a1==!=!x=");
        send_byte(CH_NUL, 1'b0);
        // Blank kinds, a closed string, an integer cut by a high byte, and a
        // string left open at end of text
        send_text("\t\"x\"\r\n9");
        send_byte(8'hFF, 1'b0);
        send_text("\"a");
        send_byte(CH_NUL, 1'b1);
        pause_until_drained();

        // Random fragments; the long hold-off falls in here
        base = bytes_sent;
        while (bytes_sent - base < RANDOM_BYTES) send_random_text(30);
        pause_until_drained();

        // Calm tail: back-to-back transfers both ways
        gaps_on = 1'b0;
        calm    = 1'b1;
        base = bytes_sent;
        while (bytes_sent - base < TAIL_BYTES) send_random_text(30);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d bytes in %0d texts, %0d tokens checked in %0d cycles",
                 bytes_sent, texts_sent, tokens_checked, cycle_count);
        $display("Run: all operators, open runs at end, full-queue stall, gap-free tail");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
